// ----- src/fskrd_pkg.sv -----
// ----------------------------------------------------------------------------
// fskrd_pkg
// Types, constants and microcode for the FSK resonator demodulator.
// ----------------------------------------------------------------------------
package fskrd_pkg;

	localparam int NUM_CFG   = 8;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 4;
	localparam int SAMPLE_W  = 16;
	localparam int RES_W     = 26;
	localparam int LVL_W     = 41;
	localparam int SUM_W     = 42;
	localparam int OPA_W     = 27;
	localparam int OPB_W     = 26;
	localparam int PROD_W    = OPA_W + OPB_W;
	localparam int ACC_W     = 64;
	localparam int LO_W      = 20;
	localparam int NUM_STEPS = 24;
	localparam int STEP_W    = 5;
	localparam int FRAC_RES  = 16;
	localparam int FRAC_FLT  = 20;
	localparam int OUT_W     = 8;

	typedef logic signed [CFG_W-1:0]    cfg_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [RES_W-1:0]    res_t;
	typedef logic signed [LVL_W-1:0]    lvl_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [OPA_W-1:0]    opa_t;
	typedef logic signed [OPB_W-1:0]    opb_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [STEP_W-1:0]          step_t;

	// register map
	localparam logic [2:0] REG_S_FAR_COS  = 3'd0;
	localparam logic [2:0] REG_S_FAR_SIN  = 3'd1;
	localparam logic [2:0] REG_S_STEP_COS = 3'd2;
	localparam logic [2:0] REG_S_STEP_SIN = 3'd3;
	localparam logic [2:0] REG_M_FAR_COS  = 3'd4;
	localparam logic [2:0] REG_M_FAR_SIN  = 3'd5;
	localparam logic [2:0] REG_M_STEP_COS = 3'd6;
	localparam logic [2:0] REG_M_STEP_SIN = 3'd7;

	localparam cfg_t CFG_RESET [NUM_CFG] = '{
		18'sd11992, -18'sd5339, 18'sd64109, 18'sd9982,
		-18'sd1372, 18'sd13054, 18'sd64347, 18'sd8300
	};

	// low-pass coefficients, Q.20
	localparam opb_t FLT_B0 = 26'sd393;
	localparam opb_t FLT_B1 = 26'sd787;
	localparam opb_t FLT_A1 = -26'sd2038933;
	localparam opb_t FLT_A2 = 26'sd991930;

	localparam acc_t HALF_RES = 64'sd32768;
	localparam acc_t HALF_FLT = 64'sd524288;

	localparam lvl_t LOAD_LEVEL     = 41'sd3932160;
	localparam lvl_t NEG_LOAD_LEVEL = -41'sd3932160;
	localparam lvl_t DECAY_LEVEL    = 41'sd3276800;
	localparam lvl_t NEG_DECAY_LEVEL = -41'sd3276800;

	typedef enum logic [3:0] {
		A_X2, A_SRE, A_SIM, A_MRE, A_MIM,
		A_E0LO, A_E0HI, A_F0LO, A_F0HI, A_F1LO, A_F1HI, A_SUMLO, A_SUMHI
	} opa_sel_t;

	typedef enum logic [2:0] {
		B_CFG, B_SAME, B_B0, B_B1, B_A1, B_A2
	} opb_sel_t;

	typedef enum logic [1:0] {
		I_PRESET, I_HALF_RES, I_HALF_FLT
	} init_sel_t;

	typedef struct packed {
		opa_sel_t  a_sel;
		opb_sel_t  b_sel;
		logic [2:0] reg_idx;
		logic      neg;
		logic      sh20;
		logic      first;
		init_sel_t init_sel;
	} uop_t;

	typedef struct packed {
		logic  valid;
		step_t step;
		logic  neg;
		logic  sh20;
		logic  first;
	} mac_ctrl_t;

	typedef struct packed {
		logic  valid;
		step_t step;
	} mac_tag_t;

	// last step of each accumulation group
	localparam step_t STEP_SP_END = 5'd2;
	localparam step_t STEP_SQ_END = 5'd5;
	localparam step_t STEP_MP_END = 5'd8;
	localparam step_t STEP_MQ_END = 5'd11;
	localparam step_t STEP_Y_END  = 5'd15;
	localparam step_t STEP_F_END  = 5'd23;
	localparam step_t STEP_LAST   = STEP_W'(NUM_STEPS - 1);

	// resonator p/q, energy, then filter with 41-bit operands split lo/hi
	localparam uop_t UCODE [NUM_STEPS] = '{
		'{A_X2,    B_CFG,  REG_S_FAR_COS,  1'b1, 1'b0, 1'b1, I_PRESET},
		'{A_SRE,   B_CFG,  REG_S_STEP_COS, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_SIM,   B_CFG,  REG_S_STEP_SIN, 1'b1, 1'b0, 1'b0, I_HALF_RES},
		'{A_X2,    B_CFG,  REG_S_FAR_SIN,  1'b1, 1'b0, 1'b1, I_HALF_RES},
		'{A_SIM,   B_CFG,  REG_S_STEP_COS, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_SRE,   B_CFG,  REG_S_STEP_SIN, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_X2,    B_CFG,  REG_M_FAR_COS,  1'b1, 1'b0, 1'b1, I_PRESET},
		'{A_MRE,   B_CFG,  REG_M_STEP_COS, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_MIM,   B_CFG,  REG_M_STEP_SIN, 1'b1, 1'b0, 1'b0, I_HALF_RES},
		'{A_X2,    B_CFG,  REG_M_FAR_SIN,  1'b1, 1'b0, 1'b1, I_HALF_RES},
		'{A_MIM,   B_CFG,  REG_M_STEP_COS, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_MRE,   B_CFG,  REG_M_STEP_SIN, 1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_SRE,   B_SAME, REG_S_FAR_COS,  1'b1, 1'b0, 1'b1, I_HALF_RES},
		'{A_SIM,   B_SAME, REG_S_FAR_COS,  1'b1, 1'b0, 1'b0, I_HALF_RES},
		'{A_MRE,   B_SAME, REG_S_FAR_COS,  1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_MIM,   B_SAME, REG_S_FAR_COS,  1'b0, 1'b0, 1'b0, I_HALF_RES},
		'{A_E0LO,  B_B1,   REG_S_FAR_COS,  1'b0, 1'b0, 1'b1, I_HALF_FLT},
		'{A_E0HI,  B_B1,   REG_S_FAR_COS,  1'b0, 1'b1, 1'b0, I_HALF_FLT},
		'{A_F0LO,  B_A1,   REG_S_FAR_COS,  1'b1, 1'b0, 1'b0, I_HALF_FLT},
		'{A_F0HI,  B_A1,   REG_S_FAR_COS,  1'b1, 1'b1, 1'b0, I_HALF_FLT},
		'{A_F1LO,  B_A2,   REG_S_FAR_COS,  1'b1, 1'b0, 1'b0, I_HALF_FLT},
		'{A_F1HI,  B_A2,   REG_S_FAR_COS,  1'b1, 1'b1, 1'b0, I_HALF_FLT},
		'{A_SUMLO, B_B0,   REG_S_FAR_COS,  1'b0, 1'b0, 1'b0, I_HALF_FLT},
		'{A_SUMHI, B_B0,   REG_S_FAR_COS,  1'b0, 1'b1, 1'b0, I_HALF_FLT}
	};

	function automatic res_t sat_res(acc_t v);
		if (v > 64'sd33554431)
			return 26'sd33554431;
		else if (v < -64'sd33554432)
			return -26'sd33554432;
		else
			return v[RES_W-1:0];
	endfunction

	function automatic lvl_t sat_lvl(acc_t v);
		if (v > 64'sd1099511627775)
			return 41'sd1099511627775;
		else if (v < -64'sd1099511627776)
			return -41'sd1099511627776;
		else
			return v[LVL_W-1:0];
	endfunction

endpackage

// ----- src/fskrd_delay.sv -----
// ----------------------------------------------------------------------------
// fskrd_delay
// Circular sample delay line; returns the sample one symbol back.
// ----------------------------------------------------------------------------
module fskrd_delay #(
	parameter int DEPTH = 161
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  fskrd_pkg::sample_t wr_data,
	output fskrd_pkg::sample_t rd_data
);
	import fskrd_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sample_t          mem [DEPTH];
	sample_t          rd_q;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] rd_addr;

	assign rd_addr = (idx_q == IDX_W'(DEPTH - 1)) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_data;
			rd_q       <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fill_q <= '0;
			hit_q  <= 1'b0;
		end else if (wr_en) begin
			idx_q <= rd_addr;
			hit_q <= CNT_W'(rd_addr) < fill_q;
			if (fill_q != CNT_W'(DEPTH))
				fill_q <= fill_q + 1'b1;
		end
	end

	// entries not yet written read as zero
	assign rd_data = hit_q ? rd_q : '0;

endmodule

// ----- src/fskrd_mac.sv -----
// ----------------------------------------------------------------------------
// fskrd_mac
// Shared 27x26 multiplier, registered, feeding a 64-bit accumulator.
// ----------------------------------------------------------------------------
module fskrd_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fskrd_pkg::opa_t      op_a,
	input  fskrd_pkg::opb_t      op_b,
	input  fskrd_pkg::acc_t      init_val,
	input  fskrd_pkg::mac_ctrl_t ctrl,
	output fskrd_pkg::acc_t      acc,
	output fskrd_pkg::mac_tag_t  tag
);
	import fskrd_pkg::*;

	prod_t     prod_s1;
	acc_t      init_s1;
	mac_ctrl_t ctrl_s1;
	acc_t      acc_q;
	mac_tag_t  tag_q;
	acc_t      prod_ext;
	acc_t      addend;
	acc_t      base;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		init_s1 <= init_val;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign addend   = ctrl_s1.sh20 ? (prod_ext <<< FRAC_FLT) : prod_ext;
	assign base     = ctrl_s1.first ? init_s1 : acc_q;

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid)
			acc_q <= ctrl_s1.neg ? (base - addend) : (base + addend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			tag_q   <= '0;
		end else begin
			ctrl_s1     <= ctrl;
			tag_q.valid <= ctrl_s1.valid;
			tag_q.step  <= ctrl_s1.step;
		end
	end

	assign acc = acc_q;
	assign tag = tag_q;

endmodule

// ----- src/fsk_resonator_demodulator_top.sv -----
// ----------------------------------------------------------------------------
// fsk_resonator_demodulator_top
// FSK demodulator: mark/space resonators, energy difference, low-pass,
// carrier hold with hysteresis, one bit per audio sample.
// ----------------------------------------------------------------------------
//  channel   dir  beat                          handshake
//  s_*       in   tdata[15:0] sample            tvalid/tready
//  m_*       out  tdata[0] bit_res,             tvalid/tready
//                 tdata[1] carrier_present
//  cfg_*     in   cfg_index -> 18-bit register  cfg_we, no wait
//
//  Each beat runs: accept, 24 issues of the shared multiplier, pipeline
//  drain, then one commit.
//  s_tready is high only while no sample is in work.
//  The output register holds one result; commit waits while it is unread.
//  Reset clears resonator state, filter history, hold and delay fill counts; cfg takes its defaults.
// ----------------------------------------------------------------------------
module fsk_resonator_demodulator_top #(
	parameter int SYMBOL_SAMPLES = 160,
	parameter int HOLD_LENGTH    = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [15:0] sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [0] bit_res, [1] carrier_present
	input  logic                cfg_we,
	input  fskrd_pkg::cfg_idx_t cfg_index,
	input  fskrd_pkg::cfg_t     cfg_data
);
	import fskrd_pkg::*;

	localparam int HOLD_W = $clog2(HOLD_LENGTH + 1);
	localparam logic [HOLD_W-1:0] HOLD_INIT = HOLD_W'(HOLD_LENGTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t      state_q;
	step_t       step_q;
	cfg_t        cfg_q [NUM_CFG];
	sample_t     sample_q;
	sample_t     x_val;
	res_t        p_q, sre_q, sim_q, mre_q, mim_q;
	lvl_t        y_q, f_q, e0_q, e1_q, f0_q, f1_q;
	sum_t        sum_q;
	logic [HOLD_W-1:0] hold_q, hold_next;
	logic        bit_q, carrier_q, m_tvalid_q;
	logic        accept, commit;
	uop_t        uop;
	opa_t        a_val;
	opb_t        b_val;
	cfg_t        cfg_sel;
	acc_t        init_val;
	mac_ctrl_t   mac_ctrl;
	acc_t        acc;
	mac_tag_t    mac_tag;
	res_t        res16;
	lvl_t        lvl16, lvl20;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++)
				cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	fskrd_delay #(
		.DEPTH (SYMBOL_SAMPLES + 1)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (s_tdata),
		.rd_data (x_val)
	);

	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == STEP_LAST) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (mac_tag.valid && (mac_tag.step == STEP_F_END))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand selection
	assign uop     = UCODE[step_q];
	assign cfg_sel = cfg_q[uop.reg_idx];

	always_comb begin
		case (uop.a_sel)
			A_X2:    a_val = {{(OPA_W-SAMPLE_W-1){x_val[SAMPLE_W-1]}}, x_val, 1'b0};
			A_SRE:   a_val = {sre_q[RES_W-1], sre_q};
			A_SIM:   a_val = {sim_q[RES_W-1], sim_q};
			A_MRE:   a_val = {mre_q[RES_W-1], mre_q};
			A_MIM:   a_val = {mim_q[RES_W-1], mim_q};
			A_E0LO:  a_val = {{(OPA_W-LO_W){1'b0}}, e0_q[LO_W-1:0]};
			A_E0HI:  a_val = {{(OPA_W-LVL_W+LO_W){e0_q[LVL_W-1]}}, e0_q[LVL_W-1:LO_W]};
			A_F0LO:  a_val = {{(OPA_W-LO_W){1'b0}}, f0_q[LO_W-1:0]};
			A_F0HI:  a_val = {{(OPA_W-LVL_W+LO_W){f0_q[LVL_W-1]}}, f0_q[LVL_W-1:LO_W]};
			A_F1LO:  a_val = {{(OPA_W-LO_W){1'b0}}, f1_q[LO_W-1:0]};
			A_F1HI:  a_val = {{(OPA_W-LVL_W+LO_W){f1_q[LVL_W-1]}}, f1_q[LVL_W-1:LO_W]};
			A_SUMLO: a_val = {{(OPA_W-LO_W){1'b0}}, sum_q[LO_W-1:0]};
			A_SUMHI: a_val = {{(OPA_W-SUM_W+LO_W){sum_q[SUM_W-1]}}, sum_q[SUM_W-1:LO_W]};
			default: a_val = '0;
		endcase
	end

	always_comb begin
		case (uop.b_sel)
			B_CFG:   b_val = {{(OPB_W-CFG_W){cfg_sel[CFG_W-1]}}, cfg_sel};
			B_SAME:  b_val = a_val[OPB_W-1:0];
			B_B0:    b_val = FLT_B0;
			B_B1:    b_val = FLT_B1;
			B_A1:    b_val = FLT_A1;
			B_A2:    b_val = FLT_A2;
			default: b_val = '0;
		endcase
	end

	// rounding half is folded into the group's start value
	always_comb begin
		case (uop.init_sel)
			I_PRESET:   init_val = {{(ACC_W-SAMPLE_W-17){sample_q[SAMPLE_W-1]}}, sample_q,
			                        1'b0, 1'b1, 15'b0};
			I_HALF_RES: init_val = HALF_RES;
			I_HALF_FLT: init_val = HALF_FLT;
			default:    init_val = '0;
		endcase
	end

	always_comb begin
		mac_ctrl.valid = (state_q == ST_RUN);
		mac_ctrl.step  = step_q;
		mac_ctrl.neg   = uop.neg;
		mac_ctrl.sh20  = uop.sh20;
		mac_ctrl.first = uop.first;
	end

	fskrd_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_a     (a_val),
		.op_b     (b_val),
		.init_val (init_val),
		.ctrl     (mac_ctrl),
		.acc      (acc),
		.tag      (mac_tag)
	);

	assign res16 = sat_res(acc >>> FRAC_RES);
	assign lvl16 = sat_lvl(acc >>> FRAC_RES);
	assign lvl20 = sat_lvl(acc >>> FRAC_FLT);

	// group results
	always_ff @(posedge clk) begin
		if (mac_tag.valid) begin
			unique case (mac_tag.step) inside
				STEP_SP_END, STEP_MP_END: p_q <= res16;
				STEP_Y_END: begin
					y_q   <= lvl16;
					sum_q <= {lvl16[LVL_W-1], lvl16} + {e1_q[LVL_W-1], e1_q};
				end
				STEP_F_END: f_q <= lvl20;
				default: ;
			endcase
		end
	end

	always_comb begin
		if ((f_q > LOAD_LEVEL) || (f_q < NEG_LOAD_LEVEL))
			hold_next = HOLD_INIT;
		else if ((hold_q != '0) && (f_q < DECAY_LEVEL) && (f_q > NEG_DECAY_LEVEL))
			hold_next = hold_q - 1'b1;
		else
			hold_next = hold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sre_q  <= '0;
			sim_q  <= '0;
			mre_q  <= '0;
			mim_q  <= '0;
			e0_q   <= '0;
			e1_q   <= '0;
			f0_q   <= '0;
			f1_q   <= '0;
			hold_q <= '0;
		end else begin
			if (mac_tag.valid && (mac_tag.step == STEP_SQ_END)) begin
				sre_q <= p_q;
				sim_q <= res16;
			end
			if (mac_tag.valid && (mac_tag.step == STEP_MQ_END)) begin
				mre_q <= p_q;
				mim_q <= res16;
			end
			if (commit) begin
				e1_q   <= e0_q;
				e0_q   <= y_q;
				f1_q   <= f0_q;
				f0_q   <= f_q;
				hold_q <= hold_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			bit_q     <= (hold_next != '0) ? !f_q[LVL_W-1] : 1'b1;
			carrier_q <= (hold_next != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (commit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W-2){1'b0}}, carrier_q, bit_q};

	// checks
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mac_tag.valid && !mac_ctrl.valid)
		else $error("multiplier pipeline busy while idle");

	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HOLD_INIT)
		else $error("hold counter above its load value");

	a_idle_is_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] || m_tdata[0]))
		else $error("space bit without carrier");

	a_filter_wb_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_tag.valid && (mac_tag.step == STEP_F_END)) |-> (state_q == ST_DRAIN))
		else $error("filter result out of sequence");

endmodule

// ----- tb/sv/fsk_resonator_demodulator_top_tb.sv -----
// ----------------------------------------------------------------------------
// fsk_resonator_demodulator_top_tb
// Streams audio samples through the FSK demodulator and checks each output
// beat against a fixed-point model of the tone resonators, the energy
// low-pass and the carrier hold. The run covers several coefficient sets,
// the extreme sets among them, with random gaps on both streams.
// ----------------------------------------------------------------------------
module fsk_resonator_demodulator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fskrd_pkg::*;

	localparam int SYMBOL_SAMPLES = 160;
	localparam int HOLD_LENGTH    = 50;
	localparam int TAP_DEPTH      = SYMBOL_SAMPLES + 1;
	localparam real HALF_PERIOD   = 6.0;
	localparam int MAX_GAP        = 18;
	localparam int DRAIN_CYCLES   = 60;
	localparam int CYCLE_LIMIT    = 400000;

	localparam longint SAMPLE_SCALE = 131072;
	localparam longint LPF_B0 = 393;
	localparam longint LPF_B1 = 787;
	localparam longint LPF_B2 = 393;
	localparam longint LPF_A1 = -2038933;
	localparam longint LPF_A2 = 991930;
	localparam longint LOAD_THR  = 60 * 65536;
	localparam longint DECAY_THR = 50 * 65536;

	localparam int SAMPLE_HI = 32767;
	localparam int SAMPLE_LO = -32768;
	localparam real SAMPLE_HZ = 48000.0;
	localparam real MARK_HZ   = 980.0;
	localparam real SPACE_HZ  = 1180.0;
	localparam real TWO_PI    = 6.283185307179586;

	localparam cfg_t COEF_DEFAULT [NUM_CFG] = '{
		18'sd11992, -18'sd5339, 18'sd64109, 18'sd9982,
		-18'sd1372, 18'sd13054, 18'sd64347, 18'sd8300
	};
	localparam cfg_t COEF_MAX = 18'sd131071;
	localparam cfg_t COEF_MIN = -18'sd131072;

	localparam sample_t EDGE_SAMPLES [12] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555,
		16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000
	};

	typedef struct packed {
		logic bit_res;
		logic carrier_present;
	} demod_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [15:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       cfg_we;
	cfg_idx_t   cfg_index;
	cfg_t       cfg_data;

	// demodulator model state
	cfg_t    coef [NUM_CFG];
	sample_t tap_line [TAP_DEPTH];
	int      tap_pos;
	longint  sp_re, sp_im, mk_re, mk_im;
	longint  nrg_d1, nrg_d2, lvl_d1, lvl_d2;
	int      hold_cnt;

	demod_out_t bits_due [$];
	cfg_t       coef_plan [NUM_CFG];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         items_sent = 0;
	bit         steady = 1'b0;
	real        tone_phase = 0.0;

	fsk_resonator_demodulator_top #(
		.SYMBOL_SAMPLES(SYMBOL_SAMPLES),
		.HOLD_LENGTH   (HOLD_LENGTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint round_q(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic void model_reset();
		coef = COEF_DEFAULT;
		foreach (tap_line[i])
			tap_line[i] = '0;
		tap_pos = 0;
		sp_re = 0; sp_im = 0; mk_re = 0; mk_im = 0;
		nrg_d1 = 0; nrg_d2 = 0; lvl_d1 = 0; lvl_d2 = 0;
		hold_cnt = 0;
	endfunction

	// base selects the tone: far_cos, far_sin, step_cos, step_sin follow it
	function automatic void resonate(input longint s, input longint x, input int base,
			inout longint re, inout longint im);
		longint p, q;
		p = s * SAMPLE_SCALE - longint'(coef[base]) * x * 2
			+ longint'(coef[base + 2]) * re - longint'(coef[base + 3]) * im;
		q = -longint'(coef[base + 1]) * x * 2
			+ longint'(coef[base + 2]) * im + longint'(coef[base + 3]) * re;
		re = clamp_bits(round_q(p, FRAC_RES), RES_W);
		im = clamp_bits(round_q(q, FRAC_RES), RES_W);
	endfunction

	function automatic demod_out_t demodulate(sample_t smp);
		longint s, x, acc, y, f;
		demod_out_t r;
		s = smp;
		tap_line[tap_pos] = smp;
		tap_pos = (tap_pos + 1) % TAP_DEPTH;
		x = tap_line[tap_pos];
		resonate(s, x, int'(REG_S_FAR_COS), sp_re, sp_im);
		resonate(s, x, int'(REG_M_FAR_COS), mk_re, mk_im);
		acc = (mk_re * mk_re + mk_im * mk_im) - (sp_re * sp_re + sp_im * sp_im);
		y = clamp_bits(round_q(acc, FRAC_RES), LVL_W);
		acc = LPF_B0 * y + LPF_B1 * nrg_d1 + LPF_B2 * nrg_d2
			- LPF_A1 * lvl_d1 - LPF_A2 * lvl_d2;
		f = clamp_bits(round_q(acc, FRAC_FLT), LVL_W);
		nrg_d2 = nrg_d1;
		nrg_d1 = y;
		lvl_d2 = lvl_d1;
		lvl_d1 = f;
		if (f > LOAD_THR || f < -LOAD_THR)
			hold_cnt = HOLD_LENGTH;
		else if (hold_cnt > 0 && f < DECAY_THR && f > -DECAY_THR)
			hold_cnt--;
		r.carrier_present = (hold_cnt > 0);
		r.bit_res = (hold_cnt > 0) ? (f >= 0) : 1'b1;
		return r;
	endfunction

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic sample_t tone_sample(real hz, real amp, int noise);
		int v;
		tone_phase += TWO_PI * hz / SAMPLE_HZ;
		if (tone_phase > TWO_PI)
			tone_phase -= TWO_PI;
		v = $rtoi(amp * 32767.0 * $sin(tone_phase))
			+ int'($urandom_range(0, 2 * noise)) - noise;
		if (v > SAMPLE_HI)
			v = SAMPLE_HI;
		if (v < SAMPLE_LO)
			v = SAMPLE_LO;
		return sample_t'(v);
	endfunction

	// all calls start and end at a falling edge
	task automatic send_sample(input sample_t smp);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= smp;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		bits_due.push_back(demodulate(smp));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (bits_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_coef(input cfg_idx_t idx, input cfg_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx < NUM_CFG)
			coef[idx[2:0]] = val;
		@(negedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_coef_set();
		for (int i = 0; i < NUM_CFG; i++)
			write_coef(cfg_idx_t'(i), coef_plan[i]);
		end_writes();
	endtask

	// FSK bursts with random content, some symbols cut short, then a quiet (at times
	// random) stretch long enough for the carrier hold to run out now and then
	task automatic send_bursts(input int count);
		int stop_at, seg_len, noise, quiet;
		real amp, hz;
		bit harsh;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			amp = real'($urandom_range(5, 95)) / 100.0;
			noise = $urandom_range(0, 1500);
			repeat ($urandom_range(1, 3)) begin
				hz = $urandom_range(0, 1) ? MARK_HZ : SPACE_HZ;
				seg_len = ($urandom_range(0, 3) == 0) ?
					$urandom_range(10, SYMBOL_SAMPLES) : SYMBOL_SAMPLES;
				for (int k = 0; k < seg_len && items_sent < stop_at; k++)
					send_sample(tone_sample(hz, amp, noise));
			end
			quiet = $urandom_range(20, 260);
			harsh = ($urandom_range(0, 7) == 0);
			for (int k = 0; k < quiet && items_sent < stop_at; k++)
				send_sample(harsh ? sample_t'($urandom) : tone_sample(0.0, 0.0, noise));
		end
	endtask

	task automatic test_edge_samples();
		foreach (EDGE_SAMPLES[i])
			send_sample(EDGE_SAMPLES[i]);
		steady = 1'b1;
		for (int i = 0; i < 8; i++)
			send_sample(i[0] ? sample_t'(SAMPLE_LO) : sample_t'(SAMPLE_HI));
		steady = 1'b0;
		drain();
	endtask

	task automatic test_fsk_bursts();
		send_bursts(250);
		steady = 1'b1;
		send_bursts(150);
		steady = 1'b0;
		drain();
	endtask

	// drives the resonators into saturation
	task automatic test_coef_extremes();
		foreach (coef_plan[i])
			coef_plan[i] = COEF_MAX;
		write_coef_set();
		repeat (40) send_sample(sample_t'($urandom));
		drain();
		foreach (coef_plan[i])
			coef_plan[i] = COEF_MIN;
		write_coef_set();
		repeat (40) send_sample(sample_t'($urandom));
		drain();
		foreach (coef_plan[i])
			coef_plan[i] = ((i & 2) != 0) ? COEF_MAX : cfg_t'(0);
		write_coef_set();
		repeat (30) send_sample(sample_t'(SAMPLE_HI));
		drain();
	endtask

	// writes to unused indexes must leave the coefficients alone
	task automatic test_random_coefs();
		for (int set = 0; set < 3; set++) begin
			foreach (coef_plan[i])
				coef_plan[i] = (set == 0) ?
					cfg_t'(int'(COEF_DEFAULT[i]) + int'($urandom_range(0, 4000)) - 2000) :
					cfg_t'($urandom);
			write_coef_set();
			write_coef(cfg_idx_t'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)),
				cfg_t'($urandom));
			end_writes();
			repeat (40) send_sample($urandom_range(0, 1) ?
				tone_sample($urandom_range(0, 1) ? MARK_HZ : SPACE_HZ, 0.6, 500) :
				sample_t'($urandom));
			drain();
		end
	endtask

	task automatic test_restored_defaults();
		coef_plan = COEF_DEFAULT;
		write_coef_set();
		steady = 1'b1;
		send_bursts(110);
		steady = 1'b0;
		send_bursts(120);
		drain();
	endtask

	// output side: random stall before each beat
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		demod_out_t want;
		if (m_tvalid && m_tready) begin
			if (bits_due.size() == 0) begin
				$display("%0t: output beat with none expected, got tdata %h",
					$time, m_tdata);
				mismatch_count++;
			end else begin
				want = bits_due.pop_front();
				if (m_tdata[0] !== want.bit_res) begin
					$display("%0t: bit_res expected %0b got %0b",
						$time, want.bit_res, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[1] !== want.carrier_present) begin
					$display("%0t: carrier_present expected %0b got %0b",
						$time, want.carrier_present, m_tdata[1]);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		model_reset();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_edge_samples();
		test_fsk_bursts();
		test_coef_extremes();
		test_random_coefs();
		test_restored_defaults();
		drain();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
